@@ hw/rtl/fcp_pkg.sv @@
// fcp_pkg: shared constants, result kinds, controller states and the
// command/status structs between the parser controller and datapath.
// No dependencies.
package fcp_pkg;

  // sysex buffer depth and longest run given out for one end byte
  localparam int SYSEX_CAPACITY = 32;
  localparam int MAX_RUN        = 32;

  localparam int ADDR_W = $clog2(SYSEX_CAPACITY);
  localparam int CNT_W  = $clog2(SYSEX_CAPACITY + 1);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int IDX_W  = 5;

  // command bytes
  localparam logic [7:0] CMD_DIGITAL = 8'h90;
  localparam logic [7:0] CMD_REPORT  = 8'hD0;
  localparam logic [7:0] CMD_ANALOG  = 8'hE0;
  localparam logic [7:0] CMD_SYSEX   = 8'hF0;
  localparam logic [7:0] CMD_PINMODE = 8'hF4;
  localparam logic [7:0] CMD_END     = 8'hF7;
  localparam logic [7:0] CMD_VERSION = 8'hF9;
  localparam logic [7:0] CMD_RESET   = 8'hFF;

  // result kinds; KIND_NONE marks no pending command
  typedef enum logic [2:0] {
    KIND_ANALOG  = 3'd0,
    KIND_DIGITAL = 3'd1,
    KIND_PINMODE = 3'd2,
    KIND_REPORT  = 3'd3,
    KIND_VERSION = 3'd4,
    KIND_RESET   = 3'd5,
    KIND_SYSEX   = 3'd6,
    KIND_NONE    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input byte transfer this cycle
    logic fetch;    // read next sysex byte into the output register
    logic advance;  // output transfer done, step the run index
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic one;      // current byte gives a single result
    logic run;      // current byte ends a non-empty sysex frame
    logic more;     // result in the output register is not the last of its run
  } dp_sts_t;

endpackage

@@ hw/rtl/fcp_in_if.sv @@
// fcp_in_if: valid/ready channel carrying one received link byte.
// No dependencies.
interface fcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/fcp_out_if.sv @@
// fcp_out_if: valid/ready channel carrying one decoded parser event.
// No dependencies.
interface fcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  msg_kind;
  logic [6:0]  channel;
  logic [13:0] value;
  logic [4:0]  byte_index;
  logic        last;

  modport source (output valid, output msg_kind, output channel, output value,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input msg_kind, input channel, input value,
                  input byte_index, input last, output ready);
endinterface

@@ hw/rtl/fcp_ctrl.sv @@
// fcp_ctrl: handshake controller of the command parser.
// Depends on fcp_pkg.
module fcp_ctrl
  import fcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.one) begin
            state_nxt = ST_SEND;
          end else if (sts.run) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.more) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_FETCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // an accepted byte never lands while a result is still held
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> state_r == ST_IDLE)
    else $error("byte accepted while busy");

  // a fetch is always followed by an offered result
  a_fetch_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |=> out_valid)
    else $error("fetch not followed by result");

  // an unfinished run goes back to fetch after its transfer
  a_more_refetch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sts.more) |=> state_r == ST_FETCH)
    else $error("run stopped early");

endmodule

@@ hw/rtl/fcp_datapath.sv @@
// fcp_datapath: parser registers, sysex buffer and the output register.
// Depends on fcp_pkg.
module fcp_datapath
  import fcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  rx_byte,
  input  ctrl_cmd_t   cmd,
  output dp_sts_t     sts,
  output logic [2:0]  msg_kind,
  output logic [6:0]  channel,
  output logic [13:0] value,
  output logic [4:0]  byte_index,
  output logic        last
);

  // parser state
  logic             in_sysex_r, in_sysex_nxt;
  logic [CNT_W-1:0] sysex_cnt_r, sysex_cnt_nxt;
  logic [1:0]       awaited_r, awaited_nxt;
  kind_t            pend_r, pend_nxt;
  logic [3:0]       chan_hold_r, chan_hold_nxt;
  logic [6:0]       first_r, first_nxt;

  // run bookkeeping
  logic [RUN_W-1:0] run_idx_r;
  logic [RUN_W-1:0] run_len_r, run_len_nxt;

  // sysex buffer
  logic [7:0] mem [SYSEX_CAPACITY];
  logic       wr_en;

  // output register
  kind_t       kind_r;
  logic [6:0]  ochan_r;
  logic [13:0] value_r;
  logic [4:0]  idx_r;
  logic        last_r;

  // single result decoded from the current byte
  kind_t       one_kind;
  logic [6:0]  one_chan;
  logic [13:0] one_val;
  logic [7:0]  cmd_code;

  // byte decode
  always_comb begin
    in_sysex_nxt  = in_sysex_r;
    sysex_cnt_nxt = sysex_cnt_r;
    awaited_nxt   = awaited_r;
    pend_nxt      = pend_r;
    chan_hold_nxt = chan_hold_r;
    first_nxt     = first_r;
    run_len_nxt   = run_len_r;
    wr_en         = 1'b0;
    sts.one       = 1'b0;
    sts.run       = 1'b0;
    sts.more      = (kind_r == KIND_SYSEX) && !last_r;
    one_kind      = KIND_VERSION;
    one_chan      = '0;
    one_val       = '0;
    cmd_code      = (rx_byte[7:4] != 4'hF) ? {rx_byte[7:4], 4'h0} : rx_byte;

    if (in_sysex_r) begin
      if (rx_byte == CMD_END) begin
        in_sysex_nxt = 1'b0;
        sts.run      = (sysex_cnt_r != '0);
        run_len_nxt  = (32'(sysex_cnt_r) > MAX_RUN) ? RUN_W'(MAX_RUN)
                                                    : RUN_W'(sysex_cnt_r);
      end else if (32'(sysex_cnt_r) >= SYSEX_CAPACITY) begin
        // overflow drops the frame
        in_sysex_nxt = 1'b0;
      end else begin
        wr_en         = 1'b1;
        sysex_cnt_nxt = sysex_cnt_r + CNT_W'(1);
      end
    end else if (awaited_r != 2'd0 && !rx_byte[7]) begin
      awaited_nxt = awaited_r - 2'd1;
      if (awaited_r == 2'd2) begin
        first_nxt = rx_byte[6:0];
      end else begin
        pend_nxt = KIND_NONE;
        case (pend_r)
          KIND_ANALOG, KIND_DIGITAL: begin
            sts.one  = 1'b1;
            one_kind = pend_r;
            one_chan = {3'd0, chan_hold_r};
            one_val  = {rx_byte[6:0], first_r};
          end
          KIND_PINMODE: begin
            sts.one  = 1'b1;
            one_kind = KIND_PINMODE;
            one_chan = first_r;
            one_val  = {7'd0, rx_byte[6:0]};
          end
          KIND_REPORT: begin
            sts.one  = 1'b1;
            one_kind = KIND_REPORT;
            one_chan = {3'd0, chan_hold_r};
            one_val  = {7'd0, rx_byte[6:0]};
          end
          default: ;
        endcase
      end
    end else begin
      // channel capture for every byte below the system range
      if (rx_byte[7:4] != 4'hF) begin
        chan_hold_nxt = rx_byte[3:0];
      end
      unique case (cmd_code)
        CMD_DIGITAL: begin
          awaited_nxt = 2'd2;
          pend_nxt    = KIND_DIGITAL;
        end
        CMD_ANALOG: begin
          awaited_nxt = 2'd2;
          pend_nxt    = KIND_ANALOG;
        end
        CMD_PINMODE: begin
          awaited_nxt = 2'd2;
          pend_nxt    = KIND_PINMODE;
        end
        CMD_REPORT: begin
          awaited_nxt = 2'd1;
          pend_nxt    = KIND_REPORT;
        end
        CMD_SYSEX: begin
          in_sysex_nxt  = 1'b1;
          sysex_cnt_nxt = '0;
        end
        CMD_VERSION: begin
          sts.one  = 1'b1;
          one_kind = KIND_VERSION;
        end
        CMD_RESET: begin
          sts.one       = 1'b1;
          one_kind      = KIND_RESET;
          in_sysex_nxt  = 1'b0;
          sysex_cnt_nxt = '0;
          awaited_nxt   = 2'd0;
          pend_nxt      = KIND_NONE;
          chan_hold_nxt = '0;
          first_nxt     = '0;
        end
        default: ;
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r  <= 1'b0;
      sysex_cnt_r <= '0;
      awaited_r   <= 2'd0;
      pend_r      <= KIND_NONE;
      chan_hold_r <= '0;
      first_r     <= '0;
      run_len_r   <= '0;
      run_idx_r   <= '0;
    end else begin
      if (cmd.accept) begin
        in_sysex_r  <= in_sysex_nxt;
        sysex_cnt_r <= sysex_cnt_nxt;
        awaited_r   <= awaited_nxt;
        pend_r      <= pend_nxt;
        chan_hold_r <= chan_hold_nxt;
        first_r     <= first_nxt;
        if (sts.run) begin
          run_len_r <= run_len_nxt;
          run_idx_r <= '0;
        end
      end else if (cmd.advance) begin
        run_idx_r <= run_idx_r + RUN_W'(1);
      end
    end
  end

  // sysex buffer write
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[sysex_cnt_r[ADDR_W-1:0]] <= rx_byte;
    end
  end

  // output register, loaded by a single result or a buffer read
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.one) begin
      kind_r  <= one_kind;
      ochan_r <= one_chan;
      value_r <= one_val;
      idx_r   <= '0;
      last_r  <= 1'b1;
    end else if (cmd.fetch) begin
      kind_r  <= KIND_SYSEX;
      ochan_r <= '0;
      value_r <= {6'd0, mem[run_idx_r[ADDR_W-1:0]]};
      idx_r   <= run_idx_r[IDX_W-1:0];
      last_r  <= (RUN_W'(run_idx_r + RUN_W'(1)) == run_len_r);
    end
  end

  assign msg_kind   = kind_r;
  assign channel    = ochan_r;
  assign value      = value_r;
  assign byte_index = idx_r;
  assign last       = last_r;

  // buffer fill never passes its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sysex_cnt_r) <= SYSEX_CAPACITY)
    else $error("sysex count past capacity");

  // a wait for data always has a command to complete
  a_wait_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (awaited_r != 2'd0) |-> (pend_r != KIND_NONE))
    else $error("data awaited with nothing pending");

  // buffer reads stay inside the run
  a_fetch_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> (run_idx_r < run_len_r))
    else $error("sysex read past run end");

endmodule

@@ hw/rtl/firmata_command_parser.sv @@
// firmata_command_parser: top level of the Firmata byte-stream decoder.
// Depends on fcp_pkg, fcp_in_if, fcp_out_if, fcp_ctrl and fcp_datapath.

// Takes one received link byte per input transfer and gives decoded
// events on the output channel. A byte that completes no event is taken
// at once and the next byte can follow in the next cycle. A byte that
// completes a command gives its event from the output register on the
// next cycle, and the next byte is taken after that event's transfer.
// The sysex end byte gives the buffered frame (up to 32 bytes) as a run:
// each byte is read from the single read port of the sysex buffer in
// ST_FETCH and then offered in ST_SEND until its output transfer.
// Input is held off during a run.
module firmata_command_parser
  import fcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fcp_in_if.sink    in_ch,
  fcp_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  fcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (in_ch.rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .msg_kind   (out_ch.msg_kind),
    .channel    (out_ch.channel),
    .value      (out_ch.value),
    .byte_index (out_ch.byte_index),
    .last       (out_ch.last)
  );

endmodule

@@ tb/sv/tb_firmata_command_parser.sv @@
// tb_firmata_command_parser: self-checking bench for the Firmata byte decoder,
// with directed command sequences, sysex frames and random traffic.
// Depends on fcp_pkg, fcp_in_if, fcp_out_if and firmata_command_parser.
module tb_firmata_command_parser;
  import fcp_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  chan;
    logic [13:0] val;
    logic [4:0]  idx;
    logic        fin;
  } fw_event_t;

  logic clk = 1'b0;
  logic rst_n;

  fcp_in_if  in_ch();
  fcp_out_if out_ch();

  firmata_command_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirrored decoder state
  logic       sx_open;
  int         sx_len;
  logic [7:0] sx_buf [SYSEX_CAPACITY];
  int         data_left;
  kind_t      held_kind;
  logic [3:0] held_chan;
  logic [6:0] held_data;

  fw_event_t expected_events[$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  logic      quiet = 1'b1;  // no idling on either side while set
  int        stall_left = 0;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run timeout
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_decoder();
    sx_open   = 1'b0;
    sx_len    = 0;
    data_left = 0;
    held_kind = KIND_NONE;
    held_chan = 4'd0;
    held_data = 7'd0;
  endfunction

  function automatic void push_event(input kind_t k, input logic [6:0] c,
                                     input logic [13:0] v, input logic [4:0] i,
                                     input logic f);
    fw_event_t e;
    e.kind = k;
    e.chan = c;
    e.val  = v;
    e.idx  = i;
    e.fin  = f;
    expected_events.push_back(e);
  endfunction

  // expected events for one accepted byte
  function automatic void decode_byte(input logic [7:0] b);
    int         n;
    logic [7:0] op;
    // inside a sysex frame
    if (sx_open) begin
      if (b == CMD_END) begin
        sx_open = 1'b0;
        n = sx_len;
        if (n > SYSEX_CAPACITY) n = SYSEX_CAPACITY;
        if (n > MAX_RUN) n = MAX_RUN;
        for (int i = 0; i < n; i++)
          push_event(KIND_SYSEX, 7'd0, {6'd0, sx_buf[i]}, 5'(i), i + 1 == n);
      end else if (sx_len >= SYSEX_CAPACITY) begin
        sx_open = 1'b0;
      end else begin
        sx_buf[sx_len] = b;
        sx_len++;
      end
      return;
    end
    // awaited data byte
    if (data_left > 0 && b < 8'd128) begin
      data_left--;
      if (data_left > 0) begin
        held_data = b[6:0];
        return;
      end
      case (held_kind)
        KIND_ANALOG, KIND_DIGITAL:
          push_event(held_kind, {3'd0, held_chan}, {b[6:0], held_data}, 5'd0, 1'b1);
        KIND_PINMODE:
          push_event(KIND_PINMODE, held_data, {7'd0, b[6:0]}, 5'd0, 1'b1);
        KIND_REPORT:
          push_event(KIND_REPORT, {3'd0, held_chan}, {7'd0, b[6:0]}, 5'd0, 1'b1);
        default: ;
      endcase
      held_kind = KIND_NONE;
      return;
    end
    // command decode with channel capture below sysex range
    if (b < CMD_SYSEX) begin
      op        = b & 8'hF0;
      held_chan = b[3:0];
    end else begin
      op = b;
    end
    case (op)
      CMD_DIGITAL: begin
        data_left = 2;
        held_kind = KIND_DIGITAL;
      end
      CMD_ANALOG: begin
        data_left = 2;
        held_kind = KIND_ANALOG;
      end
      CMD_PINMODE: begin
        data_left = 2;
        held_kind = KIND_PINMODE;
      end
      CMD_REPORT: begin
        data_left = 1;
        held_kind = KIND_REPORT;
      end
      CMD_SYSEX: begin
        sx_open = 1'b1;
        sx_len  = 0;
      end
      CMD_VERSION: push_event(KIND_VERSION, 7'd0, 14'd0, 5'd0, 1'b1);
      CMD_RESET: begin
        clear_decoder();
        push_event(KIND_RESET, 7'd0, 14'd0, 5'd0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // one byte transfer on the input channel
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_two_data_cmd(input logic [7:0] cmd, input logic [6:0] d1,
                                   input logic [6:0] d2);
    send_byte(cmd);
    send_byte({1'b0, d1});
    send_byte({1'b0, d2});
  endtask

  // sysex frame with random content, never the end byte inside
  task automatic send_frame(input int len);
    logic [7:0] b;
    send_byte(CMD_SYSEX);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CMD_END) b = 8'h77;
      send_byte(b);
    end
    send_byte(CMD_END);
  endtask

  // hold the sender until every expected event has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic flag_mismatch(input string what, input fw_event_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp kind/ch/val/idx/last %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
               $time, what, want.kind, want.chan, want.val, want.idx, want.fin,
               out_ch.msg_kind, out_ch.channel, out_ch.value, out_ch.byte_index,
               out_ch.last);
  endtask

  // compare each output transfer with the oldest expected event
  always @(posedge clk) begin
    fw_event_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_events.size() == 0) begin
        want = '0;
        flag_mismatch("unexpected event", want);
      end else begin
        want = expected_events.pop_front();
        if (out_ch.msg_kind !== want.kind || out_ch.channel !== want.chan ||
            out_ch.value !== want.val || out_ch.byte_index !== want.idx ||
            out_ch.last !== want.fin)
          flag_mismatch("field mismatch", want);
      end
    end
  end

  // every channel command, analog and pin mode at their field extremes, no idling
  task automatic test_channel_messages();
    quiet = 1'b1;
    send_two_data_cmd(CMD_ANALOG, 7'h00, 7'h00);
    send_two_data_cmd(CMD_ANALOG | 8'h0F, 7'h7F, 7'h7F);
    send_two_data_cmd(CMD_DIGITAL | 8'h05, 7'h12, 7'h34);
    send_two_data_cmd(CMD_PINMODE, 7'h7F, 7'h7F);
    send_two_data_cmd(CMD_PINMODE, 7'h00, 7'h01);
    send_byte(CMD_REPORT | 8'h0F);
    send_byte(8'h01);
    send_byte(CMD_REPORT);
    send_byte(8'h00);
  endtask

  // version, reset, stray bytes and single-byte commands mid-wait
  task automatic test_system_messages();
    quiet = 1'b0;
    send_byte(CMD_VERSION);
    send_byte(CMD_RESET);
    send_byte(CMD_END);
    send_byte(8'hF1);
    send_byte(8'h35);
    send_byte(CMD_ANALOG | 8'h03);
    send_byte(8'h10);
    send_byte(CMD_VERSION);
    send_byte(8'h20);
    send_byte(CMD_DIGITAL | 8'h02);
    send_byte(8'h10);
    send_byte(CMD_RESET);
    send_byte(8'h20);
  endtask

  // early commands restart or leave the wait, frame opened mid-wait
  task automatic test_command_interplay();
    send_byte(CMD_ANALOG | 8'h01);
    send_byte(8'h11);
    send_two_data_cmd(CMD_DIGITAL | 8'h04, 7'h22, 7'h33);
    send_byte(CMD_DIGITAL | 8'h02);
    send_byte(8'h01);
    send_byte(8'hA7);
    send_byte(8'h02);
    send_byte(CMD_DIGITAL | 8'h01);
    send_byte(8'h05);
    send_byte(8'hF1);
    send_byte(8'h06);
    send_byte(8'h36);
    send_two_data_cmd(CMD_PINMODE, 7'h03, 7'h04);
    send_byte(CMD_ANALOG | 8'h02);
    send_byte(8'h05);
    send_byte(CMD_SYSEX);
    send_byte(8'h01);
    send_byte(CMD_END);
    send_byte(8'h09);
  endtask

  // empty frame, command bytes stored as data, short frames
  task automatic test_sysex_frames();
    send_byte(CMD_SYSEX);
    send_byte(CMD_END);
    send_byte(CMD_SYSEX);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(CMD_RESET);
    send_byte(CMD_SYSEX);
    send_byte(CMD_VERSION);
    send_byte(8'h7F);
    send_byte(CMD_END);
    send_frame(1);
  endtask

  // full buffer gives a complete run, one more byte drops the frame
  task automatic test_frame_capacity();
    send_frame(SYSEX_CAPACITY);
    wait_drained();
    send_frame(SYSEX_CAPACITY + 1);
  endtask

  // mostly well-formed messages with random content, some broken and noise
  task automatic test_random_traffic();
    int start;
    int seqs;
    int len;
    start = bytes_sent;
    seqs  = 0;
    quiet = 1'b0;
    while (bytes_sent - start < 20) begin
      seqs++;
      if (seqs == 15) wait_drained();
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      case ($urandom_range(0, 11))
        0, 1: send_two_data_cmd(CMD_ANALOG | 8'($urandom_range(0, 15)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        2, 3: send_two_data_cmd(CMD_DIGITAL | 8'($urandom_range(0, 15)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        4: send_two_data_cmd(CMD_PINMODE, 7'($urandom_range(0, 127)),
                             7'($urandom_range(0, 127)));
        5: begin
          send_byte(CMD_REPORT | 8'($urandom_range(0, 15)));
          send_byte(8'($urandom_range(0, 127)));
        end
        6: send_byte($urandom_range(0, 1) ? CMD_VERSION : CMD_RESET);
        7, 8: begin
          if ($urandom_range(0, 9) == 0) len = $urandom_range(30, 33);
          else len = $urandom_range(0, 6);
          send_frame(len);
        end
        // command cut short by the next sequence
        9: begin
          send_byte($urandom_range(0, 1) ? (CMD_ANALOG | 8'($urandom_range(0, 15)))
                                         : CMD_PINMODE);
          send_byte(8'($urandom_range(0, 127)));
        end
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    clear_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_channel_messages();
    test_system_messages();
    test_command_interplay();
    wait_drained();
    test_sysex_frames();
    test_frame_capacity();
    test_random_traffic();

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fcp_pkg.sv
hw/rtl/fcp_in_if.sv
hw/rtl/fcp_out_if.sv
hw/rtl/fcp_ctrl.sv
hw/rtl/fcp_datapath.sv
hw/rtl/firmata_command_parser.sv
tb/sv/tb_firmata_command_parser.sv
